// ===== src/spct_pkg.sv =====
// Package for the shape pair collision test: widths, payload layout, stage records.
// Depends on nothing; used by shape_pair_collision_test.
package spct_pkg;

    // Coordinate width; all other widths follow from it (range 8..32)
    localparam int COORD_W = 16;
    localparam int SIZE_W  = COORD_W - 1;      // width, height, radius
    localparam int HI_W    = COORD_W + 1;      // x + width, y + height
    localparam int DX_W    = COORD_W + 2;      // differences against clamp points
    localparam int MAG_W   = COORD_W + 1;      // absolute distance per axis
    localparam int RAD_W   = COORD_W;          // sum of two radii
    localparam int MSQ_W   = 2 * MAG_W;
    localparam int RSQ_W   = 2 * RAD_W;
    localparam int SUM_W   = MSQ_W + 1;

    // Stream layout
    localparam int SHAPE_BITS = 2 * COORD_W + 3 * SIZE_W;
    localparam int IN_BITS    = 2 * SHAPE_BITS;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [1:0] {
        KIND_CC,   // circle with circle
        KIND_CR,   // circle with rectangle
        KIND_RR    // rectangle with rectangle
    } pair_kind_t;

    // One shape as packed in tdata, x in the lowest bits
    typedef struct packed {
        logic        [SIZE_W-1:0]  radius;
        logic        [SIZE_W-1:0]  height;
        logic        [SIZE_W-1:0]  width;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } shape_t;

    typedef struct packed {
        shape_t second;
        shape_t first;
    } pair_t;

    // Stage 1: ordered shapes and upper edges
    typedef struct packed {
        pair_kind_t               kind;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [HI_W-1:0]    chx;
        logic signed [HI_W-1:0]    chy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [HI_W-1:0]    phx;
        logic signed [HI_W-1:0]    phy;
        logic        [RAD_W-1:0]   rad;
    } s1_t;

    // Stage 2: per-axis distances and early decision
    typedef struct packed {
        logic               early_hit;
        logic               use_dist;
        logic [MAG_W-1:0]   magx;
        logic [MAG_W-1:0]   magy;
        logic [RAD_W-1:0]   rad;
    } s2_t;

    // Stage 3: squares
    typedef struct packed {
        logic               early_hit;
        logic               use_dist;
        logic [MSQ_W-1:0]   sqx;
        logic [MSQ_W-1:0]   sqy;
        logic [RSQ_W-1:0]   rsq;
    } s3_t;

endpackage

// ===== src/shape_pair_collision_test.sv =====
// Top level of the shape pair collision test: four-stage pipeline with output register.
// Depends on spct_pkg.
// An accepted request passes through the stage 1, 2, 3 and 4 registers before its result reaches the master side.
// Throughput: one request per cycle; the stages are decoupled by per-stage valid bits,
//   so a stalled result holds its stage and the stages behind it fill up first.
// Stage work: edge sums, clamp and distance, squares, final add and compare.
// Reset: rst_n clears all stage valid bits asynchronously; payload is not reset.
module shape_pair_collision_test
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata, low bit up: first_x, first_y, first_width, first_height, first_radius,
    //   second_x, second_y, second_width, second_height, second_radius, zero fill
    input  logic [spct_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser, low bit up: first_is_rect, second_is_rect
    input  logic [spct_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata, low bit up: overlap, zero fill
    output logic [spct_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int W  = spct_pkg::COORD_W;
    localparam int XE = spct_pkg::DX_W - W;

    // Stage registers
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    spct_pkg::s1_t   s1_reg, s1_next;
    spct_pkg::s2_t   s2_reg, s2_next;
    spct_pkg::s3_t   s3_reg, s3_next;
    logic            hit_reg, hit_next;

    // Stage enables: a stage moves when it is empty or the next one moves
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // Stage 1: classify pair, pick circle and partner, form upper edges
    spct_pkg::pair_t  pair_in;
    spct_pkg::shape_t c_shape, p_shape;
    logic             a_rect, b_rect;

    always_comb
    begin
        pair_in = spct_pkg::pair_t'(s_tdata[spct_pkg::IN_BITS-1:0]);
        a_rect  = s_tuser[0];
        b_rect  = s_tuser[1];

        if (a_rect && b_rect)
            s1_next.kind = spct_pkg::KIND_RR;
        else if (a_rect || b_rect)
            s1_next.kind = spct_pkg::KIND_CR;
        else
            s1_next.kind = spct_pkg::KIND_CC;

        // rectangle goes to the partner slot
        if (a_rect && !b_rect)
        begin
            c_shape = pair_in.second;
            p_shape = pair_in.first;
        end
        else
        begin
            c_shape = pair_in.first;
            p_shape = pair_in.second;
        end

        s1_next.cx  = c_shape.x;
        s1_next.cy  = c_shape.y;
        s1_next.px  = p_shape.x;
        s1_next.py  = p_shape.y;
        s1_next.chx = $signed({c_shape.x[W-1], c_shape.x}) + $signed({2'b00, c_shape.width});
        s1_next.chy = $signed({c_shape.y[W-1], c_shape.y}) + $signed({2'b00, c_shape.height});
        s1_next.phx = $signed({p_shape.x[W-1], p_shape.x}) + $signed({2'b00, p_shape.width});
        s1_next.phy = $signed({p_shape.y[W-1], p_shape.y}) + $signed({2'b00, p_shape.height});

        if (!a_rect && !b_rect)
            s1_next.rad = {1'b0, pair_in.first.radius} + {1'b0, pair_in.second.radius};
        else
            s1_next.rad = {1'b0, c_shape.radius};
    end

    // Stage 2: span tests, clamp into the rectangle, per-axis distance
    logic signed [spct_pkg::DX_W-1:0] cx_e, cy_e, px_e, py_e;
    logic signed [spct_pkg::DX_W-1:0] chx_e, chy_e, phx_e, phy_e;
    logic signed [spct_pkg::DX_W-1:0] nx, ny, dx, dy;
    logic                             rr_hit, c_in_box;

    always_comb
    begin
        cx_e  = {{XE{s1_reg.cx[W-1]}}, s1_reg.cx};
        cy_e  = {{XE{s1_reg.cy[W-1]}}, s1_reg.cy};
        px_e  = {{XE{s1_reg.px[W-1]}}, s1_reg.px};
        py_e  = {{XE{s1_reg.py[W-1]}}, s1_reg.py};
        chx_e = {s1_reg.chx[spct_pkg::HI_W-1], s1_reg.chx};
        chy_e = {s1_reg.chy[spct_pkg::HI_W-1], s1_reg.chy};
        phx_e = {s1_reg.phx[spct_pkg::HI_W-1], s1_reg.phx};
        phy_e = {s1_reg.phy[spct_pkg::HI_W-1], s1_reg.phy};

        // touching edges count
        rr_hit   = !(chx_e < px_e || cx_e > phx_e || chy_e < py_e || cy_e > phy_e);
        c_in_box = (cx_e >= px_e) && (cx_e <= phx_e) && (cy_e >= py_e) && (cy_e <= phy_e);

        if (cx_e < px_e)
            nx = px_e;
        else if (cx_e > phx_e)
            nx = phx_e;
        else
            nx = cx_e;

        if (cy_e < py_e)
            ny = py_e;
        else if (cy_e > phy_e)
            ny = phy_e;
        else
            ny = cy_e;

        case (s1_reg.kind)
            spct_pkg::KIND_RR:
            begin
                s2_next.early_hit = rr_hit;
                s2_next.use_dist  = 1'b0;
                dx = cx_e - px_e;
                dy = cy_e - py_e;
            end
            spct_pkg::KIND_CR:
            begin
                s2_next.early_hit = c_in_box;
                s2_next.use_dist  = 1'b1;
                dx = cx_e - nx;
                dy = cy_e - ny;
            end
            default:
            begin
                s2_next.early_hit = 1'b0;
                s2_next.use_dist  = 1'b1;
                dx = cx_e - px_e;
                dy = cy_e - py_e;
            end
        endcase

        s2_next.magx = dx[spct_pkg::DX_W-1] ? spct_pkg::MAG_W'(-dx) : spct_pkg::MAG_W'(dx);
        s2_next.magy = dy[spct_pkg::DX_W-1] ? spct_pkg::MAG_W'(-dy) : spct_pkg::MAG_W'(dy);
        s2_next.rad  = s1_reg.rad;
    end

    // Stage 3: squares
    always_comb
    begin
        s3_next.early_hit = s2_reg.early_hit;
        s3_next.use_dist  = s2_reg.use_dist;
        s3_next.sqx       = s2_reg.magx * s2_reg.magx;
        s3_next.sqy       = s2_reg.magy * s2_reg.magy;
        s3_next.rsq       = s2_reg.rad * s2_reg.rad;
    end

    // Stage 4: early hit, or strict compare of squared distance against squared radius
    logic [spct_pkg::SUM_W-1:0] dist_sum;

    always_comb
    begin
        dist_sum = {1'b0, s3_reg.sqx} + {1'b0, s3_reg.sqy};
        hit_next = s3_reg.early_hit ||
                   (s3_reg.use_dist && (dist_sum < spct_pkg::SUM_W'(s3_reg.rsq)));
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
        if (en4)
            hit_reg <= hit_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(spct_pkg::OUT_DATA_W-1){1'b0}}, hit_reg};

    // An accepted request lands in stage 1
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted request missing from stage 1");

    // A blocked stage 3 keeps its contents
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en3) |=> (v3_reg && $stable(s3_reg)))
        else $error("stage 3 changed while stalled");

    // Full pipeline under backpressure refuses new requests
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready) |-> !s_tready)
        else $error("request accepted into full pipeline");

    // Zero radius and no early hit never reports overlap
    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && en4 && !s3_reg.early_hit && (s3_reg.rsq == '0)) |=> !m_tdata[0])
        else $error("overlap reported for zero squared radius");

endmodule
